>>> src/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg
// Shared widths, constants, register codes and control types of the stereo
// voice mixer.
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned GAIN_W    = 10;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [GAIN_W-1:0] MASTER_GAIN_RST = 10'd179;
  localparam logic [GAIN_W-1:0] MUSIC_GAIN_RST  = 10'd256;

  localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 16'sh8000;

  // 8-bit path gain ceiling
  localparam logic [7:0] GAIN8_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASTER_GAIN = 1'b0,
    REG_MUSIC_GAIN  = 1'b1
  } svm_reg_e;

  // Pipeline enables from the control path to each side's datapath
  typedef struct packed {
    logic s2_load;    // stage 1 item moves into stage 2
    logic acc_upd;    // stage 2 item retires into the accumulator
    logic frame_end;  // retiring item closes the frame
    logic out_load;   // stage 3 frame moves into the result register
  } svm_ctrl_t;

endpackage

>>> src/svm_if.sv
// ----------------------------------------------------------------------------
// svm_if
// Valid/ready channels of the stereo voice mixer: voice items in, stereo
// frames out.
// ----------------------------------------------------------------------------
interface svm_voice_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [svm_pkg::SAMPLE_W-1:0]   voice_sample;
  logic                                  sample_is_8bit;
  logic        [svm_pkg::GAIN_W-1:0]     left_gain;
  logic        [svm_pkg::GAIN_W-1:0]     right_gain;
  logic                                  voice_valid;
  logic                                  last_voice;
  logic signed [svm_pkg::SAMPLE_W-1:0]   music_left;
  logic signed [svm_pkg::SAMPLE_W-1:0]   music_right;

  modport source (
    output valid, voice_sample, sample_is_8bit, left_gain, right_gain,
           voice_valid, last_voice, music_left, music_right,
    input  ready
  );
  modport sink (
    input  valid, voice_sample, sample_is_8bit, left_gain, right_gain,
           voice_valid, last_voice, music_left, music_right,
    output ready
  );
endinterface

interface svm_mix_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [svm_pkg::SAMPLE_W-1:0]   left_out;
  logic signed [svm_pkg::SAMPLE_W-1:0]   right_out;

  modport source (
    output valid, left_out, right_out,
    input  ready
  );
  modport sink (
    input  valid, left_out, right_out,
    output ready
  );
endinterface

>>> src/stereo_voice_mixer.sv
// ----------------------------------------------------------------------------
// stereo_voice_mixer
// Accumulates scaled mono voice samples into left and right sums and emits
// one saturated stereo frame, mixed with music, on each frame's last item.
// ----------------------------------------------------------------------------
//
//  Channel   Port      Dir   Carries
//  --------  --------  ----  ------------------------------------------------
//  voice     voice_i   in    one voice sample, gains, flags, music samples
//  mix       mix_o     out   left_out / right_out, one per frame
//  config    cfg_*_i   in    master_gain (index 0), music_gain (index 1)
//
//  One voice transaction is taken every cycle unless voice_i.ready is low.
//  Four register stages: input register, scaled terms, frame snapshot, result
//  register, passed in that order by each frame on its way to mix_o.
//  Reset clears the accumulators, the stage valids and loads the gain
//  registers with 179 and 256.
//  A stalled result only backs up stages that carry frame ends; items that
//  close no frame keep draining into the accumulators, so voice_i.ready
//  drops only when stages 2 and 3 and the result register all hold frames
//  waiting for the result port and the input register is occupied.
//
module stereo_voice_mixer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  svm_voice_if.sink                          voice_i,
  svm_mix_if.source                          mix_o,
  input  logic                               cfg_we_i,
  input  logic [svm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [svm_pkg::GAIN_W-1:0]         cfg_wdata_i
);
  import svm_pkg::*;

  // Configuration registers
  logic [GAIN_W-1:0] master_gain_q;
  logic [GAIN_W-1:0] music_gain_q;

  // Stage 1: input register
  logic                       s1_vld_q;
  logic signed [SAMPLE_W-1:0] s1_sample_q;
  logic                       s1_is8_q;
  logic        [GAIN_W-1:0]   s1_lgain_q;
  logic        [GAIN_W-1:0]   s1_rgain_q;
  logic                       s1_voice_q;
  logic                       s1_last_q;
  logic signed [SAMPLE_W-1:0] s1_mleft_q;
  logic signed [SAMPLE_W-1:0] s1_mright_q;

  // Stage 2/3 and result valids
  logic s2_vld_q, s2_last_q;
  logic s3_vld_q;
  logic out_vld_q;

  logic      in_fire;
  logic      out_en, s3_adv, s3_free;
  logic      s2_go, s2_free;
  logic      s1_go, s1_free;
  svm_ctrl_t ctrl;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_gain_q <= MASTER_GAIN_RST;
      music_gain_q  <= MUSIC_GAIN_RST;
    end else if (cfg_we_i) begin
      case (svm_reg_e'(cfg_idx_i))
        REG_MASTER_GAIN: master_gain_q <= cfg_wdata_i;
        REG_MUSIC_GAIN:  music_gain_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. Each stage frees up when its item moves on; an item that
  // closes no frame leaves stage 2 into the accumulator without needing
  // room further down.
  // --------------------------------------------------------------------------
  assign out_en  = !out_vld_q || mix_o.ready;
  assign s3_adv  = s3_vld_q && out_en;
  assign s3_free = !s3_vld_q || out_en;
  assign s2_go   = s2_vld_q && (!s2_last_q || s3_free);
  assign s2_free = !s2_vld_q || s2_go;
  assign s1_go   = s1_vld_q && s2_free;
  assign s1_free = !s1_vld_q || s2_free;

  assign voice_i.ready = s1_free;
  assign in_fire       = voice_i.valid && s1_free;

  assign ctrl.s2_load   = s1_go;
  assign ctrl.acc_upd   = s2_go;
  assign ctrl.frame_end = s2_last_q;
  assign ctrl.out_load  = s3_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_vld_q <= 1'b1;
      end else if (s1_go) begin
        s1_vld_q <= 1'b0;
      end

      if (s1_go) begin
        s2_vld_q  <= 1'b1;
        s2_last_q <= s1_last_q;
      end else if (s2_go) begin
        s2_vld_q <= 1'b0;
      end

      if (s2_go && s2_last_q) begin
        s3_vld_q <= 1'b1;
      end else if (s3_adv) begin
        s3_vld_q <= 1'b0;
      end

      if (s3_adv) begin
        out_vld_q <= 1'b1;
      end else if (mix_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Input payload register, loaded on an accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_sample_q <= voice_i.voice_sample;
      s1_is8_q    <= voice_i.sample_is_8bit;
      s1_lgain_q  <= voice_i.left_gain;
      s1_rgain_q  <= voice_i.right_gain;
      s1_voice_q  <= voice_i.voice_valid;
      s1_last_q   <= voice_i.last_voice;
      s1_mleft_q  <= voice_i.music_left;
      s1_mright_q <= voice_i.music_right;
    end
  end

  // --------------------------------------------------------------------------
  // Per-side datapaths
  // --------------------------------------------------------------------------
  svm_side u_left (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .sample_i      (s1_sample_q),
    .is8_i         (s1_is8_q),
    .voice_en_i    (s1_voice_q),
    .gain_i        (s1_lgain_q),
    .music_i       (s1_mleft_q),
    .master_gain_i (master_gain_q),
    .music_gain_i  (music_gain_q),
    .out_o         (mix_o.left_out)
  );

  svm_side u_right (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .sample_i      (s1_sample_q),
    .is8_i         (s1_is8_q),
    .voice_en_i    (s1_voice_q),
    .gain_i        (s1_rgain_q),
    .music_i       (s1_mright_q),
    .master_gain_i (master_gain_q),
    .music_gain_i  (music_gain_q),
    .out_o         (mix_o.right_out)
  );

  assign mix_o.valid = out_vld_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Input back-pressure only when the whole chain holds waiting frames.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !voice_i.ready |-> (s1_vld_q && s2_vld_q && s2_last_q && s3_vld_q && out_vld_q))
    else $error("voice input stalled with room in the pipeline");

  // A frame end leaving stage 2 always finds stage 3 free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_go && s2_last_q) |-> (!s3_vld_q || out_en))
    else $error("frame end overwrote a pending frame");

  // A new result only comes from a frame held in stage 3.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(s3_vld_q))
    else $error("result raised without a frame in stage 3");

  // A stalled result keeps the frame behind it in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !mix_o.ready && s3_vld_q) |=> s3_vld_q)
    else $error("stage 3 frame lost during output stall");

endmodule

>>> src/svm_side.sv
// ----------------------------------------------------------------------------
// svm_side
// One output side: voice scaling, music scaling, frame accumulator, final
// master scaling and saturation into the result register.
// ----------------------------------------------------------------------------
module svm_side (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  svm_pkg::svm_ctrl_t                  ctrl_i,
  input  logic signed [svm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                is8_i,
  input  logic                                voice_en_i,
  input  logic        [svm_pkg::GAIN_W-1:0]   gain_i,
  input  logic signed [svm_pkg::SAMPLE_W-1:0] music_i,
  input  logic        [svm_pkg::GAIN_W-1:0]   master_gain_i,
  input  logic        [svm_pkg::GAIN_W-1:0]   music_gain_i,
  output logic signed [svm_pkg::SAMPLE_W-1:0] out_o
);
  import svm_pkg::*;

  localparam int unsigned PROD_W = SAMPLE_W + GAIN_W + 1;  // 27
  localparam int unsigned TERM_W = PROD_W - 8;             // 19
  localparam int unsigned ACC_W  = 32;
  localparam int unsigned FPROD_W = ACC_W + GAIN_W + 1;    // 43
  localparam int unsigned FTERM_W = FPROD_W - 8;           // 35
  localparam int unsigned MIX_W  = FTERM_W + 1;

  localparam logic signed [MIX_W-1:0] MIX_HI =
    {{(MIX_W-SAMPLE_W){OUT_MAX[SAMPLE_W-1]}}, OUT_MAX};
  localparam logic signed [MIX_W-1:0] MIX_LO =
    {{(MIX_W-SAMPLE_W){OUT_MIN[SAMPLE_W-1]}}, OUT_MIN};

  logic        [7:0]          gain_clamp;
  logic        [7:0]          gain8;
  logic signed [SAMPLE_W-1:0] mul_a;
  logic signed [GAIN_W:0]     mul_b;
  logic signed [PROD_W-1:0]   vprod;
  logic signed [PROD_W-1:0]   mprod;
  logic signed [TERM_W-1:0]   term_d, term_q;
  logic signed [TERM_W-1:0]   musterm_q;
  logic signed [TERM_W-1:0]   mus3_q;
  logic signed [ACC_W-1:0]    acc_q, acc_sum;
  logic signed [ACC_W-1:0]    frame_q;
  logic signed [FPROD_W-1:0]  fprod;
  logic signed [MIX_W-1:0]    mix;
  logic signed [SAMPLE_W-1:0] sat_d, out_q;

  // 8-bit path: gain clamped to 255 and rounded down to a multiple of 8;
  // one multiplier serves both sample formats.
  assign gain_clamp = (gain_i > {2'b00, GAIN8_MAX}) ? GAIN8_MAX : gain_i[7:0];
  assign gain8      = {gain_clamp[7:3], 3'b000};
  assign mul_a      = is8_i ? {{(SAMPLE_W-8){sample_i[7]}}, sample_i[7:0]} : sample_i;
  assign mul_b      = is8_i ? {3'b000, gain8} : {1'b0, gain_i};
  assign vprod      = mul_a * mul_b;
  assign mprod      = music_i * $signed({1'b0, music_gain_i});

  always_comb begin
    if (!voice_en_i) begin
      term_d = '0;
    end else if (is8_i) begin
      term_d = vprod[TERM_W-1:0];
    end else begin
      term_d = vprod[PROD_W-1:8];   // floor of /256
    end
  end

  assign acc_sum = acc_q + {{(ACC_W-TERM_W){term_q[TERM_W-1]}}, term_q};
  assign fprod   = frame_q * $signed({1'b0, master_gain_i});
  assign mix     = {fprod[FPROD_W-1], fprod[FPROD_W-1:8]}
                 + {{(MIX_W-TERM_W){mus3_q[TERM_W-1]}}, mus3_q};

  always_comb begin
    if (mix > MIX_HI) begin
      sat_d = OUT_MAX;
    end else if (mix < MIX_LO) begin
      sat_d = OUT_MIN;
    end else begin
      sat_d = mix[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_upd) begin
      acc_q <= ctrl_i.frame_end ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s2_load) begin
      term_q    <= term_d;
      musterm_q <= mprod[PROD_W-1:8];
    end
    if (ctrl_i.acc_upd && ctrl_i.frame_end) begin
      frame_q <= acc_sum;
      mus3_q  <= musterm_q;
    end
    if (ctrl_i.out_load) begin
      out_q <= sat_d;
    end
  end

  assign out_o = out_q;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stereo_voice_mixer: a directed table, two long
// full-scale frames and random phases at several gain settings. A local
// mixing model predicts each frame that the directed table does not fix,
// from the accepted voice transactions; the output port is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import svm_pkg::*;

  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned RESET_CYCLES = 12;
  // The input, term, frame and result registers sit between the last item and mix_o; allow slack.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT = 200000;
  localparam longint unsigned TIMEOUT_NS = 5000000;
  // Voices in each of the two full-scale frames; large sums, rails on output.
  localparam int unsigned LONG_VOICES = 128;
  // Receiver starts its long hold-off once this many frames have been seen.
  localparam int unsigned HOLD_AFTER_FRAMES = 80;
  localparam int unsigned HOLD_CYCLES = 400;

  // One voice transaction as the bench sees it.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                is8;
    logic [GAIN_W-1:0]   lgain;
    logic [GAIN_W-1:0]   rgain;
    logic                vvalid;
    logic                last;
    logic [SAMPLE_W-1:0] mleft;
    logic [SAMPLE_W-1:0] mright;
  } voice_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
  } mix_frame_t;

  // Directed table row; a fixed frame replaces the model's where it is set.
  typedef struct packed {
    voice_item_t item;
    logic        has_fixed;
    mix_frame_t  fixed;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [GAIN_W-1:0]    cfg_wdata;

  svm_voice_if voice_if ();
  svm_mix_if   mix_if ();

  stereo_voice_mixer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .voice_i     (voice_if),
    .mix_o       (mix_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Mixing model: own copy of the gain registers and the two frame sums.
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0] master_gain_q;
  logic [GAIN_W-1:0] music_gain_q;
  logic [31:0]       left_sum;
  logic [31:0]       right_sum;

  mix_frame_t frames_due[$];
  int         err_count;
  int         frames_done;

  // Contribution of one voice to one side. The 8-bit path reads the low byte
  // as signed and uses the gain clamped to 255 with the low three bits
  // dropped; the 16-bit path floors sample*gain/256.
  function automatic logic [31:0] voice_term(input logic [SAMPLE_W-1:0] smp,
                                             input logic is8,
                                             input logic [GAIN_W-1:0] gain);
    longint s;
    longint g;
    if (is8) begin
      s = longint'($signed(smp[7:0]));
      g = (gain > GAIN_W'(GAIN8_MAX)) ? longint'(GAIN8_MAX) : longint'(gain);
      g = g & ~longint'(7);
      return 32'(s * g);
    end
    s = longint'($signed(smp));
    g = longint'(gain);
    return 32'((s * g) >>> 8);
  endfunction

  // Final value of one side: scaled music plus scaled sum, saturated.
  function automatic logic [SAMPLE_W-1:0] mix_side(input logic [SAMPLE_W-1:0] music,
                                                   input logic [31:0] sum);
    longint v;
    v = ((longint'($signed(music)) * longint'(music_gain_q)) >>> 8)
      + ((longint'($signed(sum)) * longint'(master_gain_q)) >>> 8);
    if (v > longint'(OUT_MAX)) v = longint'(OUT_MAX);
    else if (v < longint'(OUT_MIN)) v = longint'(OUT_MIN);
    return SAMPLE_W'(v);
  endfunction

  // Advance the model by one transaction; returns 1 when a frame closes.
  function automatic bit mix_step(input voice_item_t it, output mix_frame_t fr);
    fr = '0;
    // A voice on the closing item still lands in this frame.
    if (it.vvalid) begin
      left_sum  = left_sum + voice_term(it.sample, it.is8, it.lgain);
      right_sum = right_sum + voice_term(it.sample, it.is8, it.rgain);
    end
    if (!it.last) return 1'b0;
    fr.left   = mix_side(it.mleft, left_sum);
    fr.right  = mix_side(it.mright, right_sum);
    left_sum  = '0;
    right_sum = '0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, timeout
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout, frames still due %0d", $time, frames_due.size());
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result checker: every mix transaction against the oldest predicted frame.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : mix_check
    mix_frame_t want;
    if (rst_ni === 1'b1 && mix_if.valid === 1'b1 && mix_if.ready === 1'b1) begin
      frames_done++;
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected frame, expected none, actual left %0d right %0d",
                 $time, $signed(mix_if.left_out), $signed(mix_if.right_out));
        err_count++;
      end else begin
        want = frames_due.pop_front();
        if (mix_if.left_out !== want.left) begin
          $display("%0t: left_out mismatch, expected %0d actual %0d",
                   $time, $signed(want.left), $signed(mix_if.left_out));
          err_count++;
        end
        if (mix_if.right_out !== want.right) begin
          $display("%0t: right_out mismatch, expected %0d actual %0d",
                   $time, $signed(want.right), $signed(mix_if.right_out));
          err_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready modes, plus one long hold-off so the block backs
  // up with frame ends and drops voice ready while the sender keeps pushing.
  // --------------------------------------------------------------------------
  initial begin : mix_sink
    int mode;
    int mode_left;
    int hold_left;
    bit held;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    held      = 1'b0;
    mix_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
      end else if (!held && frames_done >= HOLD_AFTER_FRAMES) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        mix_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       mix_if.ready <= 1'b1;                        // no stalls
          1:       mix_if.ready <= 1'($urandom_range(0, 1));
          2:       mix_if.ready <= ($urandom_range(0, 3) == 0); // heavy stall
          default: mix_if.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one transaction from the falling edge and hold it until taken; the
  // model runs at the accepting edge. valid stays high for a following item.
  task automatic send_item(input voice_item_t it, input bit has_fixed,
                           input mix_frame_t fixed);
    mix_frame_t fr;
    @(negedge clk_i);
    voice_if.valid          <= 1'b1;
    voice_if.voice_sample   <= it.sample;
    voice_if.sample_is_8bit <= it.is8;
    voice_if.left_gain      <= it.lgain;
    voice_if.right_gain     <= it.rgain;
    voice_if.voice_valid    <= it.vvalid;
    voice_if.last_voice     <= it.last;
    voice_if.music_left     <= it.mleft;
    voice_if.music_right    <= it.mright;
    do @(posedge clk_i); while (voice_if.ready !== 1'b1);
    if (mix_step(it, fr)) frames_due.push_back(has_fixed ? fixed : fr);
  endtask

  // Idle cycles with junk on the payload.
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      voice_if.valid        <= 1'b0;
      voice_if.voice_sample <= SAMPLE_W'($urandom);
      voice_if.last_voice   <= 1'($urandom);
    end
  endtask

  // Stop sending until every frame is out and the pipe has emptied.
  task automatic drain();
    idle_cycles(1);
    while (frames_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input svm_reg_e idx, input logic [GAIN_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    if (idx == REG_MASTER_GAIN) master_gain_q = val;
    else music_gain_q = val;
  endtask

  // Registers change only with the block idle.
  task automatic set_gains(input logic [GAIN_W-1:0] master, input logic [GAIN_W-1:0] music);
    drain();
    write_reg(REG_MASTER_GAIN, master);
    write_reg(REG_MUSIC_GAIN, music);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return SAMPLE_W'($urandom_range(0, 15)) - 16'd8;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Gains lean on zero, full scale and the 8-bit clamp point.
  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom_range(248, 264));
      3:       return GAIN_W'($urandom_range(0, 16));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic voice_item_t rand_item(input bit last);
    voice_item_t it;
    it.sample = rand_sample();
    it.is8    = 1'($urandom);
    it.lgain  = rand_gain();
    it.rgain  = rand_gain();
    it.vvalid = ($urandom_range(0, 7) != 0);  // some voiceless noise
    it.last   = last;
    it.mleft  = rand_sample();
    it.mright = rand_sample();
    return it;
  endfunction

  // Random frames, mostly short, in bursts with random gaps.
  task automatic run_phase(input int n_items);
    voice_item_t it;
    int sent;
    int burst_left;
    int flen;
    sent       = 0;
    burst_left = $urandom_range(1, 24);
    while (sent < n_items) begin
      flen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      for (int k = 0; k <= flen; k++) begin
        it = rand_item(k == flen);
        send_item(it, 1'b0, '0);
        if (it.vvalid || it.last) sent++;
        burst_left--;
        if (burst_left == 0) begin
          // a quarter of the bursts run straight into the next one
          if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
          burst_left = $urandom_range(1, 24);
        end
      end
    end
  endtask

  function automatic dir_row_t mk_row(input logic [SAMPLE_W-1:0] smp, input logic is8,
                                      input logic [GAIN_W-1:0] lg, input logic [GAIN_W-1:0] rg,
                                      input logic vv, input logic last,
                                      input logic [SAMPLE_W-1:0] ml,
                                      input logic [SAMPLE_W-1:0] mr,
                                      input logic has_fixed,
                                      input logic [SAMPLE_W-1:0] fl,
                                      input logic [SAMPLE_W-1:0] fr);
    dir_row_t r;
    r.item      = '{sample: smp, is8: is8, lgain: lg, rgain: rg, vvalid: vv, last: last,
                    mleft: ml, mright: mr};
    r.has_fixed = has_fixed;
    r.fixed     = '{left: fl, right: fr};
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stim
    dir_row_t    dir_rows[$];
    voice_item_t it;
    int          guard;

    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = REG_MASTER_GAIN;
    cfg_wdata = '0;
    voice_if.valid          = 1'b0;
    voice_if.voice_sample   = '0;
    voice_if.sample_is_8bit = 1'b0;
    voice_if.left_gain      = '0;
    voice_if.right_gain     = '0;
    voice_if.voice_valid    = 1'b0;
    voice_if.last_voice     = 1'b0;
    voice_if.music_left     = '0;
    voice_if.music_right    = '0;
    err_count     = 0;
    frames_done   = 0;
    master_gain_q = MASTER_GAIN_RST;
    music_gain_q  = MUSIC_GAIN_RST;
    left_sum      = '0;
    right_sum     = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table at reset gains (master 179, music 256).
    //                 sample   8b    lg     rg     vv    last  mus_l    mus_r  fixed
    // empty frame right after reset: all zero
    dir_rows.push_back(mk_row(16'h1234, 1'b0, 10'd5,  10'd9,  1'b0, 1'b1, 16'h0000, 16'h0000,
                              1'b1, 16'h0000, 16'h0000));
    // music alone at unity gain passes the extremes through
    dir_rows.push_back(mk_row(16'h0000, 1'b0, 10'd0,  10'd0,  1'b0, 1'b1, 16'h7fff, 16'h8000,
                              1'b1, 16'h7fff, 16'h8000));
    // voice on the closing item: full-scale voice plus full music saturates high,
    // silent right side with minimum music stays at the low rail
    dir_rows.push_back(mk_row(16'h7fff, 1'b0, 10'd1023, 10'd0, 1'b1, 1'b1, 16'h7fff, 16'h8000,
                              1'b1, 16'h7fff, 16'h8000));
    dir_rows.push_back(mk_row(16'h8000, 1'b0, 10'd0, 10'd1023, 1'b1, 1'b1, 16'h7fff, 16'h8000,
                              1'b1, 16'h7fff, 16'h8000));
    // frames built from several voices, model-checked
    dir_rows.push_back(mk_row(16'h7fff, 1'b0, 10'd1023, 10'd1023, 1'b1, 1'b0, 16'hffff, 16'hffff,
                              1'b0, 16'h0, 16'h0));
    dir_rows.push_back(mk_row(16'h8000, 1'b0, 10'd1023, 10'd0, 1'b1, 1'b0, 16'h0, 16'h0,
                              1'b0, 16'h0, 16'h0));
    // voiceless item: gains and sample must be ignored
    dir_rows.push_back(mk_row(16'h7fff, 1'b1, 10'd1023, 10'd1023, 1'b0, 1'b0, 16'h0, 16'h0,
                              1'b0, 16'h0, 16'h0));
    dir_rows.push_back(mk_row(16'h0001, 1'b0, 10'd1, 10'd256, 1'b1, 1'b1, 16'h1000, 16'hf000,
                              1'b0, 16'h0, 16'h0));
    // 8-bit path: high byte junk, gain clamp and round-down to a multiple of 8
    dir_rows.push_back(mk_row(16'h5a7f, 1'b1, 10'd1023, 10'd7, 1'b1, 1'b0, 16'h0, 16'h0,
                              1'b0, 16'h0, 16'h0));
    dir_rows.push_back(mk_row(16'h0080, 1'b1, 10'd255, 10'd256, 1'b1, 1'b0, 16'h0, 16'h0,
                              1'b0, 16'h0, 16'h0));
    dir_rows.push_back(mk_row(16'hff81, 1'b1, 10'd15, 10'd8, 1'b1, 1'b1, 16'h0000, 16'h0000,
                              1'b0, 16'h0, 16'h0));
    // 16-bit floor on negatives: -1 * 1 / 256 gives -1
    dir_rows.push_back(mk_row(16'hffff, 1'b0, 10'd1, 10'd255, 1'b1, 1'b0, 16'h0, 16'h0,
                              1'b0, 16'h0, 16'h0));
    dir_rows.push_back(mk_row(16'hffff, 1'b0, 10'd512, 10'd3, 1'b1, 1'b1, 16'h8001, 16'h7ffe,
                              1'b0, 16'h0, 16'h0));
    // sums cleared by the previous frame end: music alone again
    dir_rows.push_back(mk_row(16'h4321, 1'b1, 10'd700, 10'd300, 1'b0, 1'b1, 16'h0001, 16'hffff,
                              1'b1, 16'h0001, 16'hffff));
    // 8-bit maximum magnitude on the closing item
    dir_rows.push_back(mk_row(16'hff80, 1'b1, 10'd300, 10'd254, 1'b1, 1'b1, 16'h0000, 16'h0000,
                              1'b0, 16'h0, 16'h0));

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].has_fixed, dir_rows[i].fixed);

    // Large sums: one long frame of full-scale positive voices, then one of
    // full-scale negative voices, back to back.
    set_gains(10'd256, 10'd0);
    for (int n = 0; n < LONG_VOICES; n++) begin
      it = '{sample: 16'h7fff, is8: 1'b0, lgain: 10'd1023, rgain: 10'd1023, vvalid: 1'b1,
             last: (n == LONG_VOICES - 1), mleft: 16'h0, mright: 16'h0};
      send_item(it, 1'b0, '0);
    end
    for (int n = 0; n < LONG_VOICES; n++) begin
      it = '{sample: 16'h8000, is8: 1'b0, lgain: 10'd1023, rgain: 10'd1023, vvalid: 1'b1,
             last: (n == LONG_VOICES - 1), mleft: 16'h0, mright: 16'h0};
      send_item(it, 1'b0, '0);
    end

    // Random phases across gain settings, extremes first.
    set_gains(10'd0, 10'd0);
    run_phase(200);
    set_gains(10'd512, 10'd512);
    run_phase(250);
    set_gains(10'd1023, 10'd1023);
    run_phase(200);
    set_gains(10'd0, 10'd1023);
    run_phase(150);
    set_gains(10'd1023, 10'd0);
    run_phase(150);
    set_gains(GAIN_W'($urandom_range(0, 512)), GAIN_W'($urandom_range(0, 512)));
    run_phase(250);
    set_gains(MASTER_GAIN_RST, GAIN_W'($urandom));
    run_phase(250);

    // Wind down: everything out, then a few quiet cycles for strays.
    idle_cycles(1);
    guard = 0;
    while (frames_due.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (frames_due.size() != 0) begin
      $display("%0t: %0d frames never arrived, expected left %0d right %0d",
               $time, frames_due.size(), $signed(frames_due[0].left),
               $signed(frames_due[0].right));
      err_count++;
    end
    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
